FILE: rtl/lme_pkg.sv
// Shared types and constants for the label map edge and one-hot block.
`timescale 1ns / 1ps
package lme_pkg;

  localparam int unsigned LABEL_BITS    = 8;
  localparam int unsigned ONEHOT_BITS   = 64;
  localparam int unsigned OH_IDX_BITS   = 6;
  localparam int unsigned ML_BITS       = 6;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 11;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HORIZONTAL = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_RANGE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_W    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_H    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_LABEL  = 3'd5;

  // Field codes
  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_DRAIN  = 1'b1;
  localparam logic MODE_EDGE   = 1'b0;
  localparam logic MODE_EXPAND = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [LABEL_BITS-1:0] label;
  } in_item_t;

  typedef struct packed {
    logic                   edge_res;
    logic [ONEHOT_BITS-1:0] onehot;
    logic                   label_error;
    logic                   last_of_frame;
  } out_item_t;

  // Work held in the compute stage
  typedef enum logic [2:0] {
    OP_NONE,
    OP_EXPAND,
    OP_HORIZ,
    OP_VERT,
    OP_DRAIN
  } op_e;

  // Controls broadcast along the window cells
  typedef struct packed {
    logic clr;
    logic shift;
    logic ext_sel;
  } cell_ctl_t;

endpackage

FILE: rtl/lme_cell.sv
// One window cell: holds a label, passes it on, and compares its lane to the center.
`timescale 1ns / 1ps
module lme_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned KW  = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lme_pkg::cell_ctl_t              ctl_i,
  input  logic [lme_pkg::LABEL_BITS-1:0]  lab_i,
  input  logic [lme_pkg::LABEL_BITS-1:0]  ext_i,
  input  logic [lme_pkg::LABEL_BITS-1:0]  center_i,
  input  logic [KW-1:0]                   d_i,
  input  logic [KW-1:0]                   r_i,
  input  logic [KW-1:0]                   lim_i,
  output logic [lme_pkg::LABEL_BITS-1:0]  lab_o,
  output logic [lme_pkg::LABEL_BITS-1:0]  opnd_o,
  output logic                            miss_o
);

  logic [lme_pkg::LABEL_BITS-1:0] lab_q;
  logic [KW:0]                    k_c;
  logic                           in_rng;

  // Hold or advance the stored label
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lab_q <= '0;
    end else if (ctl_i.clr) begin
      lab_q <= '0;
    end else if (ctl_i.shift) begin
      lab_q <= lab_i;
    end
  end

  assign lab_o  = lab_q;
  assign opnd_o = ctl_i.ext_sel ? ext_i : lab_q;

  // Lane counts when within range of the center and inside the known part
  assign k_c    = (KW + 1)'(IDX);
  assign in_rng = (k_c <= {1'b0, lim_i}) &&
                  ((k_c + {1'b0, r_i}) >= {1'b0, d_i}) &&
                  (k_c <= ({1'b0, d_i} + {1'b0, r_i}));
  assign miss_o = in_rng && (opnd_o != center_i);

endmodule

FILE: rtl/lme_out_fifo.sv
// Two-entry result queue between the compute stage and the output port.
`timescale 1ns / 1ps
module lme_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lme_pkg::out_item_t push_data_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lme_pkg::out_item_t out_data_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PW    = $clog2(DEPTH);

  lme_pkg::out_item_t   buf_q [DEPTH];
  logic [PW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [PW:0]          cnt_q;
  logic                 pop;

  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = cnt_q != (PW + 1)'(DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = buf_q[rd_ptr_q];

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (pop)    rd_ptr_q <= rd_ptr_q + PW'(1);
      if (push_i && !pop)      cnt_q <= cnt_q + (PW + 1)'(1);
      else if (pop && !push_i) cnt_q <= cnt_q - (PW + 1)'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != (PW + 1)'(DEPTH)))
    else $error("result queue overflow");

endmodule

FILE: rtl/label_map_edge_and_one_hot.sv
// Top level: label map boundary detector and one-hot expander.
//
//   channel  | signals                               | direction
//   ---------+---------------------------------------+----------
//   cfg      | cfg_we_i, cfg_idx_i, cfg_data_i       | in, no wait
//   in       | in_valid_i, in_ready_o, in_data_i     | in
//   out      | out_valid_o, out_ready_i, out_data_o  | out
//
// One item per cycle unless a row-end flush or a full queue holds the input;
// a result passes through the compute stage, then the result queue. In
// horizontal edge mode the item that ends a row releases up to edge_range+1
// results, one per cycle while the queue has room. Vertical mode keeps
// per-column history in a one-read, one-write word memory, read on accept.
// Reset clears positions, window and pending drain; no clearing pass is run.
// A stalled output fills the two-entry queue, then holds the input.
`timescale 1ns / 1ps
module label_map_edge_and_one_hot #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_RANGE  = 4,
  parameter int unsigned MAX_LABEL  = 63
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lme_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [lme_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  lme_pkg::in_item_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output lme_pkg::out_item_t                   out_data_o
);

  localparam int unsigned LB    = lme_pkg::LABEL_BITS;
  localparam int unsigned WIN   = 2 * MAX_RANGE + 1;
  localparam int unsigned SLOTS = 2 * MAX_RANGE;
  localparam int unsigned KW    = $clog2(WIN);
  localparam int unsigned RB    = $clog2(MAX_RANGE + 1);
  localparam int unsigned CB    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned HB    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WB    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HWB   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WORD  = SLOTS * LB;

  // Configuration registers
  logic                          mode_q, horiz_q;
  logic [2:0]                    range_q;
  logic [10:0]                   fw_q, fh_q;
  logic [lme_pkg::ML_BITS-1:0]   ml_q;
  logic                          restart;

  // Effective settings
  logic [WB-1:0]                 effw;
  logic [HWB-1:0]                effh;
  logic [RB-1:0]                 effr;
  logic [lme_pkg::ML_BITS-1:0]   ml_eff;
  logic                          vert_mode, hmode;

  // Positions
  logic [CB-1:0] in_col_q, dr_col_q;
  logic [HB-1:0] in_row_q, dr_row_q;
  logic          pend_q;

  // Compute stage
  logic                 s1_valid_q, s1_res_q, s1_flush_q, s1_lrow_q, s1_last_q;
  lme_pkg::op_e         s1_op_q;
  logic [LB-1:0]        s1_lab_q;
  logic [KW-1:0]        s1_d_q, s1_lim_q;
  logic [CB-1:0]        s1_col_q;

  // Column history memory
  logic [WORD-1:0] mem [MAX_WIDTH];
  logic [WORD-1:0] rd_q, fwd_word_q, word, new_word;
  logic            fwd_q;
  logic [CB-1:0]   rd_addr;
  logic            mem_we;

  // Handshake and control
  logic in_acc, is_pix, is_drain, push, room, s1_done;
  logic c_last, r_last, dc_last, dr_last;
  logic c_ge_r, r_ge_r;
  lme_pkg::cell_ctl_t ctl;
  lme_pkg::out_item_t res;

  // Lanes
  logic [LB-1:0] lab_o  [WIN];
  logic [LB-1:0] opnd   [WIN];
  logic [LB-1:0] vv     [WIN];
  logic [WIN-1:0] miss;
  logic [LB-1:0] center;
  logic [KW-1:0] r_k;

  // Clamp settings
  always_comb begin
    if (fw_q == '0)                  effw = WB'(1);
    else if (32'(fw_q) > MAX_WIDTH)  effw = WB'(MAX_WIDTH);
    else                             effw = WB'(fw_q);
    if (fh_q == '0)                  effh = HWB'(1);
    else if (32'(fh_q) > MAX_HEIGHT) effh = HWB'(MAX_HEIGHT);
    else                             effh = HWB'(fh_q);
    if (range_q == '0)                 effr = RB'(1);
    else if (32'(range_q) > MAX_RANGE) effr = RB'(MAX_RANGE);
    else                               effr = RB'(range_q);
    if (32'(ml_q) > MAX_LABEL) ml_eff = lme_pkg::ML_BITS'(MAX_LABEL);
    else                       ml_eff = ml_q;
  end

  assign vert_mode = (mode_q == lme_pkg::MODE_EDGE) && !horiz_q;
  assign hmode     = (mode_q == lme_pkg::MODE_EDGE) && horiz_q;
  assign r_k       = KW'(effr);

  // Write configuration, restart the plane on a known index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= lme_pkg::MODE_EDGE;
      horiz_q <= 1'b1;
      range_q <= 3'd1;
      fw_q    <= 11'd1024;
      fh_q    <= 11'd1024;
      ml_q    <= 6'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lme_pkg::REG_MODE:       mode_q  <= cfg_data_i[0];
        lme_pkg::REG_HORIZONTAL: horiz_q <= cfg_data_i[0];
        lme_pkg::REG_EDGE_RANGE: range_q <= cfg_data_i[2:0];
        lme_pkg::REG_FRAME_W:    fw_q    <= cfg_data_i;
        lme_pkg::REG_FRAME_H:    fh_q    <= cfg_data_i;
        lme_pkg::REG_MAX_LABEL:  ml_q    <= cfg_data_i[lme_pkg::ML_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx_i)
      lme_pkg::REG_MODE, lme_pkg::REG_HORIZONTAL, lme_pkg::REG_EDGE_RANGE,
      lme_pkg::REG_FRAME_W, lme_pkg::REG_FRAME_H,
      lme_pkg::REG_MAX_LABEL: restart = cfg_we_i;
      default:                restart = 1'b0;
    endcase
  end

  // Handshake
  assign push    = s1_valid_q && s1_res_q && room;
  assign s1_done = !s1_valid_q || !s1_res_q ||
                   (push && !((s1_op_q == lme_pkg::OP_HORIZ) && s1_flush_q &&
                              (s1_d_q != '0)));
  assign in_ready_o = s1_done;
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_pix     = in_acc && (in_data_i.kind == lme_pkg::KIND_PIXEL);
  assign is_drain   = in_acc && (in_data_i.kind == lme_pkg::KIND_DRAIN);

  // Position flags
  assign c_last  = WB'(in_col_q) == (effw - WB'(1));
  assign r_last  = HWB'(in_row_q) == (effh - HWB'(1));
  assign dc_last = WB'(dr_col_q) == (effw - WB'(1));
  assign dr_last = HWB'(dr_row_q) == (effh - HWB'(1));
  assign c_ge_r  = 32'(in_col_q) >= 32'(effr);
  assign r_ge_r  = 32'(in_row_q) >= 32'(effr);

  // Advance positions and the pending drain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      dr_col_q <= '0;
      dr_row_q <= '0;
      pend_q   <= 1'b0;
    end else if (restart) begin
      in_col_q <= '0;
      in_row_q <= '0;
      dr_col_q <= '0;
      dr_row_q <= '0;
      pend_q   <= 1'b0;
    end else if (is_pix) begin
      pend_q <= vert_mode && c_last && r_last;
      if (c_last) begin
        in_col_q <= '0;
        in_row_q <= r_last ? '0 : in_row_q + HB'(1);
      end else begin
        in_col_q <= in_col_q + CB'(1);
      end
      dr_col_q <= '0;
      if (32'(effh) > 32'(effr)) dr_row_q <= HB'(32'(effh) - 32'(effr));
      else                        dr_row_q <= '0;
    end else if (is_drain && vert_mode && pend_q) begin
      if (dc_last) begin
        dr_col_q <= '0;
        dr_row_q <= dr_last ? '0 : dr_row_q + HB'(1);
        if (dr_last) pend_q <= 1'b0;
      end else begin
        dr_col_q <= dr_col_q + CB'(1);
      end
    end
  end

  // Load the compute stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_res_q   <= 1'b0;
      s1_op_q    <= lme_pkg::OP_NONE;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
      if (is_drain) begin
        s1_op_q  <= (vert_mode && pend_q) ? lme_pkg::OP_DRAIN : lme_pkg::OP_NONE;
        s1_res_q <= vert_mode && pend_q;
      end else if (mode_q == lme_pkg::MODE_EXPAND) begin
        s1_op_q  <= lme_pkg::OP_EXPAND;
        s1_res_q <= 1'b1;
      end else if (hmode) begin
        s1_op_q  <= lme_pkg::OP_HORIZ;
        s1_res_q <= c_last || c_ge_r;
      end else begin
        s1_op_q  <= lme_pkg::OP_VERT;
        s1_res_q <= r_ge_r;
      end
    end else if (s1_done) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Compute stage payload; step the row-end flush down
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_lab_q   <= in_data_i.label;
      s1_flush_q <= c_last;
      s1_lrow_q  <= r_last;
      s1_col_q   <= in_col_q;
      if (is_drain) begin
        s1_last_q <= dc_last && dr_last;
        s1_d_q    <= KW'(effh - HWB'(1) - HWB'(dr_row_q));
        s1_lim_q  <= (32'(effh) - 1 > SLOTS) ? KW'(SLOTS) : KW'(effh - HWB'(1));
      end else if (hmode) begin
        s1_last_q <= 1'b0;
        s1_d_q    <= c_ge_r ? r_k : KW'(in_col_q);
        s1_lim_q  <= (32'(in_col_q) > SLOTS) ? KW'(SLOTS) : KW'(in_col_q);
      end else begin
        // A vertical result belongs to an earlier row, never the final pixel
        s1_last_q <= (mode_q == lme_pkg::MODE_EXPAND) && c_last && r_last;
        s1_d_q    <= r_k;
        s1_lim_q  <= (32'(in_row_q) > SLOTS) ? KW'(SLOTS) : KW'(in_row_q);
      end
    end else if (push && (s1_op_q == lme_pkg::OP_HORIZ) && s1_d_q != '0) begin
      s1_d_q <= s1_d_q - KW'(1);
    end
  end

  // Read column history ahead, forward a same-column write
  assign rd_addr = is_drain ? dr_col_q : in_col_q;
  assign mem_we  = s1_valid_q && (s1_op_q == lme_pkg::OP_VERT) && s1_done;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q       <= mem[rd_addr];
      fwd_word_q <= new_word;
    end
    if (mem_we) begin
      mem[s1_col_q] <= new_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_acc) begin
      fwd_q <= mem_we && (s1_col_q == rd_addr);
    end
  end

  assign word     = fwd_q ? fwd_word_q : rd_q;
  assign new_word = {word[WORD-LB-1:0], s1_lab_q};

  // Vertical lane operands
  for (genvar k = 0; k < WIN; k++) begin : g_vv
    if (k == 0) begin : g_first
      assign vv[k] = (s1_op_q == lme_pkg::OP_VERT) ? s1_lab_q : word[LB-1:0];
    end else if (k < SLOTS) begin : g_mid
      assign vv[k] = (s1_op_q == lme_pkg::OP_VERT) ? word[(k-1)*LB +: LB]
                                                   : word[k*LB +: LB];
    end else begin : g_tail
      assign vv[k] = (s1_op_q == lme_pkg::OP_VERT) ? word[(k-1)*LB +: LB] : '0;
    end
  end

  // Window cell controls
  assign ctl.clr     = restart;
  assign ctl.shift   = is_pix && hmode;
  assign ctl.ext_sel = (s1_op_q == lme_pkg::OP_VERT) || (s1_op_q == lme_pkg::OP_DRAIN);
  assign center      = opnd[s1_d_q];

  // Row of window cells
  for (genvar k = 0; k < WIN; k++) begin : g_cell
    lme_cell #(
      .IDX (k),
      .KW  (KW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .lab_i    ((k == 0) ? in_data_i.label : lab_o[(k == 0) ? 0 : k - 1]),
      .ext_i    (vv[k]),
      .center_i (center),
      .d_i      (s1_d_q),
      .r_i      (r_k),
      .lim_i    (s1_lim_q),
      .lab_o    (lab_o[k]),
      .opnd_o   (opnd[k]),
      .miss_o   (miss[k])
    );
  end

  // Form the result
  always_comb begin
    res = '0;
    if (s1_op_q == lme_pkg::OP_EXPAND) begin
      res.label_error = s1_lab_q > LB'(ml_eff);
      if (!res.label_error) begin
        res.onehot = lme_pkg::ONEHOT_BITS'(1) << s1_lab_q[lme_pkg::OH_IDX_BITS-1:0];
      end
      res.last_of_frame = s1_last_q;
    end else if (s1_op_q == lme_pkg::OP_HORIZ) begin
      res.edge_res      = |miss;
      res.last_of_frame = s1_lrow_q && s1_flush_q && (s1_d_q == '0);
    end else begin
      res.edge_res      = |miss;
      res.last_of_frame = s1_last_q;
    end
  end

  lme_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_flush_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_res_q && (s1_op_q == lme_pkg::OP_HORIZ) && s1_flush_q &&
     (s1_d_q != '0)) |-> !in_ready_o)
    else $error("item taken during row-end flush");

  a_pend_vertical: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> vert_mode)
    else $error("drain pending outside vertical mode");

  a_onehot_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.onehot != '0)) |->
      ($onehot(out_data_o.onehot) && !out_data_o.label_error && !out_data_o.edge_res))
    else $error("malformed one-hot result");

endmodule

FILE: bench/label_map_checker.sv
// Checker for the label map block: predicts results and compares them with the output.
`timescale 1ns / 1ps
module label_map_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lme_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [lme_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  lme_pkg::in_item_t                   in_data_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  lme_pkg::out_item_t                  out_data_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import lme_pkg::*;

  localparam int MaxW  = 1024;
  localparam int MaxH  = 1024;
  localparam int MaxR  = 4;
  localparam int WinN  = 2 * MaxR + 1;
  localparam int Slots = 2 * MaxR;

  // Register copies
  logic        mode_q;
  logic        horiz_q;
  logic [2:0]  range_q;
  logic [10:0] width_q;
  logic [10:0] height_q;
  logic [5:0]  max_label_q;

  // Position and history state
  logic [7:0] row_win [WinN];
  logic [7:0] rows_mem [Slots*MaxW];
  int         in_row, in_col, out_row, out_col;
  bit         drain_pend;

  out_item_t  exp_results[$];

  function automatic int eff_w();
    return (width_q < 1) ? 1 : ((width_q > MaxW) ? MaxW : int'(width_q));
  endfunction

  function automatic int eff_h();
    return (height_q < 1) ? 1 : ((height_q > MaxH) ? MaxH : int'(height_q));
  endfunction

  function automatic int eff_r();
    return (range_q < 1) ? 1 : ((range_q > MaxR) ? MaxR : int'(range_q));
  endfunction

  task automatic restart_plane();
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    drain_pend = 1'b0;
    for (int i = 0; i < WinN; i++) row_win[i] = '0;
  endtask

  // Queue one result and advance the output position
  task automatic push_result(bit edge_b, logic [63:0] oh, bit err);
    out_item_t r;
    r.edge_res      = edge_b;
    r.onehot        = oh;
    r.label_error   = err;
    r.last_of_frame = (out_row == eff_h() - 1) && (out_col == eff_w() - 1);
    exp_results.push_back(r);
    out_col++;
    if (out_col >= eff_w()) begin
      out_col = 0;
      out_row++;
      if (out_row >= eff_h()) out_row = 0;
    end
  endtask

  function automatic logic [7:0] stored(int row, int col);
    return rows_mem[(row % Slots) * MaxW + (col % MaxW)];
  endfunction

  function automatic bit column_edge(int h, int w, int cur_row, bit use_cur, logic [7:0] cur);
    logic [7:0] v;
    logic [7:0] x;
    int         row;
    v = (use_cur && h == cur_row) ? cur : stored(h, w);
    for (int d = -eff_r(); d <= eff_r(); d++) begin
      row = h + d;
      if (row < 0 || row >= eff_h()) continue;
      if (use_cur && row > cur_row) continue;
      x = (use_cur && row == cur_row) ? cur : stored(row, w);
      if (x != v) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit row_edge(int p, int c);
    logic [7:0] v;
    v = row_win[(c - p) % WinN];
    for (int q = p - eff_r(); q <= p + eff_r(); q++) begin
      if (q < 0 || q > c) continue;
      if (row_win[(c - q) % WinN] != v) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic predict_item(in_item_t it);
    int  w, h, rr, r, c, n;
    bit  vert, err;
    w = eff_w(); h = eff_h(); rr = eff_r();
    r = in_row; c = in_col;
    vert = (mode_q == MODE_EDGE) && !horiz_q;
    if (it.kind == KIND_DRAIN) begin
      if (vert && drain_pend) begin
        push_result(column_edge(out_row, out_col, 0, 1'b0, '0), '0, 1'b0);
        if (out_row == 0 && out_col == 0) drain_pend = 1'b0;
      end
      return;
    end
    if (mode_q == MODE_EXPAND) begin
      err = it.label > max_label_q;
      push_result(1'b0, err ? 64'd0 : (64'd1 << it.label[5:0]), err);
    end else if (horiz_q) begin
      for (int i = WinN - 1; i > 0; i--) row_win[i] = row_win[i-1];
      row_win[0] = it.label;
      n = 0;
      if (c == w - 1) n = c + 1 - out_col;
      else if (c >= rr) n = c - rr + 1 - out_col;
      if (n > 5) n = 5;
      for (int i = 0; i < n; i++) push_result(row_edge(out_col, c), '0, 1'b0);
    end else begin
      // A new pixel drops any undrained results of the previous plane
      if (drain_pend) begin
        drain_pend = 1'b0; out_row = 0; out_col = 0;
      end
      if (r >= rr) push_result(column_edge(r - rr, c, r, 1'b1, it.label), '0, 1'b0);
      rows_mem[(r % Slots) * MaxW + (c % MaxW)] = it.label;
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
      if (in_row >= h) begin
        in_row = 0;
        if (vert) drain_pend = 1'b1;
      end
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (exp_results.size() == 0) begin
      $error("result with nothing expected: %0h", got);
      fail_count_o++;
      return;
    end
    want = exp_results.pop_front();
    if (got.edge_res !== want.edge_res) begin
      $error("edge_res expected %0h got %0h", want.edge_res, got.edge_res);
      fail_count_o++;
    end
    if (got.onehot !== want.onehot) begin
      $error("onehot expected %0h got %0h", want.onehot, got.onehot);
      fail_count_o++;
    end
    if (got.label_error !== want.label_error) begin
      $error("label_error expected %0h got %0h", want.label_error, got.label_error);
      fail_count_o++;
    end
    if (got.last_of_frame !== want.last_of_frame) begin
      $error("last_of_frame expected %0h got %0h", want.last_of_frame, got.last_of_frame);
      fail_count_o++;
    end
  endtask

  // Track writes, accepted items and results at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q = MODE_EDGE; horiz_q = 1'b1; range_q = 3'd1;
      width_q = 11'd1024; height_q = 11'd1024; max_label_q = 6'd1;
      restart_plane();
      exp_results.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:       mode_q      = cfg_data_i[0];
          REG_HORIZONTAL: horiz_q     = cfg_data_i[0];
          REG_EDGE_RANGE: range_q     = cfg_data_i[2:0];
          REG_FRAME_W:    width_q     = cfg_data_i[10:0];
          REG_FRAME_H:    height_q    = cfg_data_i[10:0];
          REG_MAX_LABEL:  max_label_q = cfg_data_i[5:0];
          default: ;
        endcase
        if (cfg_idx_i <= REG_MAX_LABEL) restart_plane();
      end
      if (in_valid_i && in_ready_i) predict_item(in_data_i);
      pending_o = exp_results.size();
    end
  end
endmodule

FILE: bench/tb.sv
// Testbench top: drives stimulus into the label map block and reports the verdict.
`timescale 1ns / 1ps
module tb;
  import lme_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  int          fail_count;
  int          pending;

  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;

  always #5 clk = ~clk;

  label_map_edge_and_one_hot dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  label_map_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Stall the receiver on its own changing pattern
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(10, 80);
    end
    stall_left--;
    case (stall_mode)
      0:       out_ready = 1'b1;
      1:       out_ready = $urandom_range(0, 1);
      default: out_ready = ($urandom_range(0, 3) == 0);
    endcase
  end

  // Send one item, opening a gap between bursts
  task automatic send_item(logic kind, logic [7:0] lab);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid = 1'b1;
    in_data.kind = kind;
    in_data.label = lab;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and hold until every result is in, then let the pipeline settle
  task automatic wait_idle();
    in_valid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_regs(int m, int hor, int rng, int w, int h, int ml);
    wait_idle();
    cfg_we = 1'b1;
    cfg_idx = REG_MODE;       cfg_data = m;   @(negedge clk);
    cfg_idx = REG_HORIZONTAL; cfg_data = hor; @(negedge clk);
    cfg_idx = REG_EDGE_RANGE; cfg_data = rng; @(negedge clk);
    cfg_idx = REG_FRAME_W;    cfg_data = w;   @(negedge clk);
    cfg_idx = REG_FRAME_H;    cfg_data = h;   @(negedge clk);
    cfg_idx = REG_MAX_LABEL;  cfg_data = ml;  @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic int clamp(int v, int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  initial begin
    #20ms;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    int  m, hor, rng, w, h, ml, ew, eh, er, nd;
    int  rnd_items;
    bit  paused;
    logic [7:0] lab;

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    // Directed: row boundary with full-range labels
    write_regs(MODE_EDGE, 1, 1, 4, 1, 1);
    send_item(KIND_PIXEL, 8'd0);   send_item(KIND_PIXEL, 8'd0);
    send_item(KIND_PIXEL, 8'd255); send_item(KIND_PIXEL, 8'd255);
    // Range above the maximum, row shorter than the range
    write_regs(MODE_EDGE, 1, 7, 3, 1, 1);
    send_item(KIND_PIXEL, 8'd5); send_item(KIND_PIXEL, 8'd5); send_item(KIND_PIXEL, 8'd6);
    // Column compare with range zero, drain ticks and a useless drain
    write_regs(MODE_EDGE, 0, 0, 2, 2, 1);
    send_item(KIND_PIXEL, 8'd1); send_item(KIND_PIXEL, 8'd1);
    send_item(KIND_PIXEL, 8'd1); send_item(KIND_PIXEL, 8'd2);
    send_item(KIND_DRAIN, 8'd0); send_item(KIND_DRAIN, 8'hff); send_item(KIND_DRAIN, 8'd0);
    // Plane left undrained, then a new plane starts
    write_regs(MODE_EDGE, 0, 1, 1, 2, 1);
    send_item(KIND_PIXEL, 8'd3); send_item(KIND_PIXEL, 8'd4); send_item(KIND_PIXEL, 8'd4);
    // Expand at both label limits and with wide labels
    write_regs(MODE_EXPAND, 1, 1, 2, 2, 63);
    send_item(KIND_PIXEL, 8'd0);  send_item(KIND_PIXEL, 8'd63);
    send_item(KIND_PIXEL, 8'd64); send_item(KIND_PIXEL, 8'd255);
    write_regs(MODE_EXPAND, 0, 1, 1, 1, 0);
    send_item(KIND_PIXEL, 8'd1); send_item(KIND_PIXEL, 8'd0);

    // Random phases: well-formed planes with random content, some noise
    rnd_items = 0;
    paused = 1'b0;
    while (rnd_items < 500) begin
      m   = $urandom_range(0, 1);
      hor = $urandom_range(0, 1);
      rng = $urandom_range(0, 7);
      w   = $urandom_range(1, 12);
      h   = $urandom_range(1, 6);
      ml  = ($urandom_range(0, 3) == 0) ? 63 * $urandom_range(0, 1) : $urandom_range(0, 63);
      case ($urandom_range(0, 19))
        0: begin w = 0; h = 0; end
        default: ;
      endcase
      write_regs(m, hor, rng, w, h, ml);
      ew = clamp(w, 1024); eh = clamp(h, 1024); er = clamp(rng, 4);
      repeat ($urandom_range(1, 2)) begin
        for (int i = 0; i < ew * eh; i++) begin
          if (m == MODE_EXPAND)
            lab = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 63))
                                              : 8'($urandom_range(0, 255));
          else
            lab = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 2))
                                             : 8'($urandom_range(0, 255));
          if ($urandom_range(0, 29) == 0) send_item(KIND_DRAIN, 8'($urandom_range(0, 255)));
          send_item(KIND_PIXEL, lab);
          rnd_items++;
          // Hold once mid-plane until all results are in
          if (!paused && rnd_items > 200) begin
            paused = 1'b1;
            in_valid = 1'b0;
            burst_left = 0;
            while (pending != 0) @(negedge clk);
          end
        end
        if (m == MODE_EDGE && hor == 0) begin
          nd = ((er < eh) ? er : eh) * ew;
          if ($urandom_range(0, 4) == 0) nd = $urandom_range(0, nd);
          nd += $urandom_range(0, 2);
          for (int i = 0; i < nd; i++) send_item(KIND_DRAIN, 8'($urandom_range(0, 255)));
          rnd_items += nd;
        end
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

FILE: label_map_edge_and_one_hot.f
rtl/lme_pkg.sv
rtl/lme_cell.sv
rtl/lme_out_fifo.sv
rtl/label_map_edge_and_one_hot.sv
bench/label_map_checker.sv
bench/tb.sv
